FILE: hw/rtl/rgb2hsv_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter package
// Shared types and constants for the pipelined RGB to HSV converter.
// ----------------------------------------------------------------------------
package rgb2hsv_pkg;

  localparam int unsigned COMP_W   = 8;
  localparam int unsigned HUE_W    = 11;
  localparam int unsigned QUO_W    = 9;
  localparam int unsigned DIV_STEPS = QUO_W;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam logic [HUE_W-1:0] HUE_TURN = 11'd1536;

  // Sector codes; the hue offset is the code times 512.
  localparam logic [1:0] SECTOR_RED   = 2'd0;
  localparam logic [1:0] SECTOR_GREEN = 2'd1;
  localparam logic [1:0] SECTOR_BLUE  = 2'd2;

  // One restoring division in flight: the partial remainder, the divisor,
  // the numerator bits still to be shifted in and the quotient so far.
  typedef struct packed {
    logic [COMP_W-1:0] rem;
    logic [COMP_W-1:0] divisor;
    logic [QUO_W-1:0]  num_low;
    logic [QUO_W-1:0]  quo;
  } div_lane_t;

  typedef struct packed {
    div_lane_t         sat;
    div_lane_t         mag;
    logic [1:0]        sector;
    logic              neg;
    logic              grey;
    logic [COMP_W-1:0] brightness;
  } pix_t;

endpackage

FILE: hw/rtl/rgb2hsv_front.sv
// ----------------------------------------------------------------------------
// RGB to HSV front stage
// Finds max, min and sector, and sets up both divisions.
// ----------------------------------------------------------------------------
module rgb2hsv_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [rgb2hsv_pkg::COMP_W-1:0]        red,
  input  logic [rgb2hsv_pkg::COMP_W-1:0]        green,
  input  logic [rgb2hsv_pkg::COMP_W-1:0]        blue,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output rgb2hsv_pkg::pix_t                     out_data
);
  import rgb2hsv_pkg::*;

  logic [COMP_W-1:0] hi;
  logic [COMP_W-1:0] lo;
  logic [COMP_W-1:0] delta;
  logic [COMP_W-1:0] pos;
  logic [COMP_W-1:0] negv;
  logic [COMP_W-1:0] diff_mag;
  logic [1:0]        sector;
  logic [15:0]       sat_num;
  pix_t              pix_next;

  always_comb begin
    hi = (red > green) ? red : green;
    if (blue > hi) begin
      hi = blue;
    end
    lo = (red < green) ? red : green;
    if (blue < lo) begin
      lo = blue;
    end
    delta = hi - lo;

    // Red wins ties over green, green over blue.
    if (red == hi) begin
      sector = SECTOR_RED;
      pos    = green;
      negv   = blue;
    end else if (green == hi) begin
      sector = SECTOR_GREEN;
      pos    = blue;
      negv   = red;
    end else begin
      sector = SECTOR_BLUE;
      pos    = red;
      negv   = green;
    end
    diff_mag = (pos >= negv) ? (pos - negv) : (negv - pos);

    // 255 * delta as a shift and subtract.
    sat_num = {delta, 8'd0} - {8'd0, delta};

    // Both numerators sit in a 17-bit window; its top eight bits seed the
    // remainder, which stays below the divisor, and nine bits are shifted in.
    pix_next.sat.rem     = {1'b0, sat_num[15:9]};
    pix_next.sat.divisor = hi;
    pix_next.sat.num_low = sat_num[8:0];
    pix_next.sat.quo     = '0;
    pix_next.mag.rem     = {1'b0, diff_mag[7:1]};
    pix_next.mag.divisor = delta;
    pix_next.mag.num_low = {diff_mag[0], 8'd0};
    pix_next.mag.quo     = '0;
    pix_next.sector      = sector;
    pix_next.neg         = (pos < negv);
    pix_next.grey        = (delta == '0);
    pix_next.brightness  = hi;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= pix_next;
    end
  end

endmodule

FILE: hw/rtl/rgb2hsv_div_step.sv
// ----------------------------------------------------------------------------
// RGB to HSV division step
// One registered restoring-division step for the saturation and hue lanes.
// ----------------------------------------------------------------------------
module rgb2hsv_div_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rgb2hsv_pkg::pix_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rgb2hsv_pkg::pix_t out_data
);
  import rgb2hsv_pkg::*;

  function automatic div_lane_t div_step(input div_lane_t lane);
    logic [COMP_W:0] trial;
    logic [COMP_W:0] diff;
    div_lane_t       res;
    trial = {lane.rem, lane.num_low[QUO_W-1]};
    diff  = trial - {1'b0, lane.divisor};
    res   = lane;
    if (trial >= {1'b0, lane.divisor}) begin
      res.rem = diff[COMP_W-1:0];
      res.quo = {lane.quo[QUO_W-2:0], 1'b1};
    end else begin
      res.rem = trial[COMP_W-1:0];
      res.quo = {lane.quo[QUO_W-2:0], 1'b0};
    end
    res.num_low = {lane.num_low[QUO_W-2:0], 1'b0};
    return res;
  endfunction

  pix_t pix_next;

  always_comb begin
    pix_next     = in_data;
    pix_next.sat = div_step(in_data.sat);
    pix_next.mag = div_step(in_data.mag);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= pix_next;
    end
  end

endmodule

FILE: hw/rtl/rgb2hsv_back.sv
// ----------------------------------------------------------------------------
// RGB to HSV back stage
// Adds the signed hue fraction to the sector offset, wraps, registers output.
// ----------------------------------------------------------------------------
module rgb2hsv_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  rgb2hsv_pkg::pix_t                     in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [rgb2hsv_pkg::OUT_TDATA_W-1:0]   out_data
);
  import rgb2hsv_pkg::*;

  logic [HUE_W-1:0]  offset;
  logic [HUE_W:0]    sum;
  logic [HUE_W-1:0]  hue;
  logic [COMP_W-1:0] sat;
  logic [OUT_TDATA_W-1:0] data_next;

  always_comb begin
    offset = {in_data.sector, 9'd0};
    if (in_data.neg) begin
      sum = {1'b0, offset} - {3'd0, in_data.mag.quo};
      // A negative hue wraps around the full turn.
      if (sum[HUE_W]) begin
        sum = sum + {1'b0, HUE_TURN};
      end
    end else begin
      sum = {1'b0, offset} + {3'd0, in_data.mag.quo};
    end
    hue = sum[HUE_W-1:0];
    sat = in_data.sat.quo[COMP_W-1:0];
    if (in_data.grey) begin
      hue = '0;
      sat = '0;
    end
    data_next = {5'd0, in_data.brightness, sat, hue};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

FILE: hw/rtl/rgb_to_hsv_converter_core.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter core
// Pipelined conversion of 8-bit RGB pixels to fixed-point hue, saturation
// and value.
// ----------------------------------------------------------------------------
// An accepted input transaction reaches its output transaction through one
// front stage, nine restoring-division stages and one output stage.
// One pixel per clock while m_tready is high; each stage holds one pixel and
// moves on whenever the next stage has room, so bubbles are squeezed out.
// Reset clears only the stage valid flags; the pipeline is then empty.
module rgb_to_hsv_converter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // hue[10:0], saturation[18:11],
                                 // brightness[26:19], zero[31:27]
);
  import rgb2hsv_pkg::*;

  pix_t stage_data  [DIV_STEPS+1];
  logic stage_valid [DIV_STEPS+1];
  logic stage_ready [DIV_STEPS+1];

  rgb2hsv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .red       (s_tdata[7:0]),
    .green     (s_tdata[15:8]),
    .blue      (s_tdata[23:16]),
    .out_valid (stage_valid[0]),
    .out_ready (stage_ready[0]),
    .out_data  (stage_data[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    rgb2hsv_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[i]),
      .in_ready  (stage_ready[i]),
      .in_data   (stage_data[i]),
      .out_valid (stage_valid[i+1]),
      .out_ready (stage_ready[i+1]),
      .out_data  (stage_data[i+1])
    );
  end

  rgb2hsv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stage_valid[DIV_STEPS]),
    .in_ready  (stage_ready[DIV_STEPS]),
    .in_data   (stage_data[DIV_STEPS]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
